// ===== rtl/pcso_pkg.sv =====
`timescale 1ns / 1ps

package pcso_pkg;

   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 4;
   localparam int PIXEL_W   = CHAN_W * NUM_CHAN;
   localparam int PROD_W    = 2 * CHAN_W;
   localparam int ALPHA_IDX = NUM_CHAN - 1;

   localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hff;
   localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'h00;

   // request payload: src_pixel, dst_pixel, coverage from the lowest bit up
   localparam int REQ_DATA_W = 2 * PIXEL_W + CHAN_W;

   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_type;
   typedef logic [NUM_CHAN-1:0][PROD_W-1:0] prod_type;

   // floor((x + 127) / 255) for x up to 255*255
   function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
      logic [PROD_W:0] t;
      logic [PROD_W:0] r;
      t = {1'b0, x} + (PROD_W+1)'(128);
      r = t + (t >> CHAN_W);
      return r[PROD_W-1:CHAN_W];
   endfunction

endpackage

// ===== rtl/premultiplied_coverage_source_over_top.sv =====
`timescale 1ns / 1ps

// channel | direction | transfer when          | payload
// req     | in        | req_tvalid & req_tready | src_pixel, dst_pixel, coverage
// rsp     | out       | rsp_tvalid & rsp_tready | out_pixel
//
// four register stages: coverage multiply, divide by 255 and select,
// inverse-alpha multiply, divide, add, saturate and select into the output register.
// one pixel per clock sustained while rsp_tready stays high; a request passes the stage
// registers a, b, c and d in order before its result is offered on rsp_tvalid.
// each stage holds its item while the next is full and stalled, so nothing is lost.
// reset is synchronous and clears only the stage valid bits.

module premultiplied_coverage_source_over_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // src_pixel [31:0], dst_pixel [63:32], coverage [71:64]
   input  logic [pcso_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_pixel [31:0]
   output logic [pcso_pkg::PIXEL_W-1:0]    rsp_tdata
);
   import pcso_pkg::*;

   pixel_type          req_src;
   pixel_type          req_dst;
   logic [CHAN_W-1:0]  req_cov;

   assign req_src = req_tdata[PIXEL_W-1:0];
   assign req_dst = req_tdata[2*PIXEL_W-1:PIXEL_W];
   assign req_cov = req_tdata[REQ_DATA_W-1:2*PIXEL_W];

   // stage valid bits and ready chain
   logic a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff;
   logic a_vld_in, b_vld_in, c_vld_in, d_vld_in;
   logic rdy_a, rdy_b, rdy_c, rdy_d;

   assign rdy_d = !d_vld_ff || rsp_tready;
   assign rdy_c = !c_vld_ff || rdy_d;
   assign rdy_b = !b_vld_ff || rdy_c;
   assign rdy_a = !a_vld_ff || rdy_b;
   assign req_tready = rdy_a;

   assign a_vld_in = rdy_a ? req_tvalid : a_vld_ff;
   assign b_vld_in = rdy_b ? a_vld_ff   : b_vld_ff;
   assign c_vld_in = rdy_c ? b_vld_ff   : c_vld_ff;
   assign d_vld_in = rdy_d ? c_vld_ff   : d_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
         d_vld_ff <= d_vld_in;
      end
   end

   // stage a: source times coverage
   prod_type  a_prod_ff,  a_prod_in;
   pixel_type a_src_ff,   a_dst_ff;
   logic      a_zero_ff,  a_zero_in;
   logic      a_pass_ff,  a_pass_in;

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         a_prod_in[i] = PROD_W'(req_src[i]) * PROD_W'(req_cov);
      end
      a_zero_in = (req_cov == CHAN_ZERO) || (req_src[ALPHA_IDX] == CHAN_ZERO);
      a_pass_in = (req_cov == CHAN_MAX);
   end

   always_ff @(posedge clock) begin
      if (rdy_a) begin
         a_prod_ff <= a_prod_in;
         a_src_ff  <= req_src;
         a_dst_ff  <= req_dst;
         a_zero_ff <= a_zero_in;
         a_pass_ff <= a_pass_in;
      end
   end

   // stage b: scaled source
   pixel_type b_scl_ff, b_scl_in;
   pixel_type b_dst_ff;

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         if (a_zero_ff) begin
            b_scl_in[i] = CHAN_ZERO;
         end else if (a_pass_ff) begin
            b_scl_in[i] = a_src_ff[i];
         end else begin
            b_scl_in[i] = div255(a_prod_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_b) begin
         b_scl_ff <= b_scl_in;
         b_dst_ff <= a_dst_ff;
      end
   end

   // stage c: destination times inverse scaled alpha
   prod_type          c_prod_ff, c_prod_in;
   pixel_type         c_scl_ff,  c_dst_ff;
   logic              c_sa0_ff,  c_sa0_in;
   logic              c_sa255_ff, c_sa255_in;
   logic [CHAN_W-1:0] inv_alpha;

   always_comb begin
      inv_alpha = CHAN_MAX - b_scl_ff[ALPHA_IDX];
      for (int i = 0; i < NUM_CHAN; i++) begin
         c_prod_in[i] = PROD_W'(b_dst_ff[i]) * PROD_W'(inv_alpha);
      end
      c_sa0_in   = (b_scl_ff[ALPHA_IDX] == CHAN_ZERO);
      c_sa255_in = (b_scl_ff[ALPHA_IDX] == CHAN_MAX);
   end

   always_ff @(posedge clock) begin
      if (rdy_c) begin
         c_prod_ff  <= c_prod_in;
         c_scl_ff   <= b_scl_ff;
         c_dst_ff   <= b_dst_ff;
         c_sa0_ff   <= c_sa0_in;
         c_sa255_ff <= c_sa255_in;
      end
   end

   // stage d: add, saturate, select into the output register
   pixel_type d_out_ff, d_out_in;

   always_comb begin
      logic [CHAN_W:0] sum;
      for (int i = 0; i < NUM_CHAN; i++) begin
         sum = {1'b0, c_scl_ff[i]} + {1'b0, div255(c_prod_ff[i])};
         if (c_sa0_ff) begin
            d_out_in[i] = c_dst_ff[i];
         end else if (c_sa255_ff) begin
            d_out_in[i] = c_scl_ff[i];
         end else if (sum[CHAN_W]) begin
            d_out_in[i] = CHAN_MAX;
         end else begin
            d_out_in[i] = sum[CHAN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_d) begin
         d_out_ff <= d_out_in;
      end
   end

   assign rsp_tvalid = d_vld_ff;
   assign rsp_tdata  = d_out_ff;

   // a zero source alpha or zero coverage must scale to the all-zero pixel
   a_zero_scales_to_zero: assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && rdy_b && a_zero_ff) |=> (b_scl_ff == '0))
      else $error("zero coverage or alpha did not give a zero scaled pixel");

   // transparent scaled source returns the destination
   a_clear_source_keeps_dst: assert property (@(posedge clock) disable iff (reset)
      (c_vld_ff && rdy_d && c_sa0_ff) |=> (rsp_tdata == $past(c_dst_ff)))
      else $error("transparent source did not return the destination");

   // an accepted request always occupies the first stage
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> a_vld_ff)
      else $error("accepted transfer lost at the first stage");

   // a stalled full pipe must not take new requests
   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (a_vld_ff && b_vld_ff && c_vld_ff && d_vld_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while the pipeline is full and stalled");

endmodule

// ===== bench/premultiplied_coverage_source_over_top_tb.sv =====
`timescale 1ns / 1ps

module premultiplied_coverage_source_over_top_tb;

   import pcso_pkg::*;

   localparam int ROUND_HALF  = 127;
   localparam int FULL_SCALE  = 255;
   localparam int IDLE_LIMIT  = 4000;
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // src_pixel [31:0], dst_pixel [63:32], coverage [71:64]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // out_pixel [31:0]
   logic [PIXEL_W-1:0] rsp_tdata;

   pixel_type expected_pixels[$];

   int failures = 0;
   int pixels_sent = 0;
   int pixels_checked = 0;
   int idle_cycles = 0;
   int burst_left = 20;
   bit req_valid_level = 1'b0;
   int alpha_zero_count = 0;
   int alpha_full_count = 0;
   int blended_count = 0;
   int saturated_count = 0;

   int stall_cycle = 0;
   int stall_mode = 0;

   premultiplied_coverage_source_over_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // coverage scaling with round-to-nearest divide by 255
   function automatic pixel_type scale_by_coverage(input pixel_type src,
                                                   input logic [CHAN_W-1:0] cov);
      pixel_type scaled;
      scaled = '0;
      if (cov == CHAN_ZERO || src[ALPHA_IDX] == CHAN_ZERO) return scaled;
      if (cov == CHAN_MAX) return src;
      for (int ch = 0; ch < NUM_CHAN; ch++)
         scaled[ch] = CHAN_W'((int'(src[ch]) * int'(cov) + ROUND_HALF) / FULL_SCALE);
      return scaled;
   endfunction

   // source-over of a premultiplied pixel, channels clamp at full scale
   function automatic pixel_type composite_over(input pixel_type src, input pixel_type dst);
      pixel_type blended;
      int inv_alpha;
      int sum;
      blended = '0;
      if (src[ALPHA_IDX] == CHAN_ZERO) return dst;
      if (src[ALPHA_IDX] == CHAN_MAX) return src;
      inv_alpha = FULL_SCALE - int'(src[ALPHA_IDX]);
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
         sum = int'(src[ch]) + (int'(dst[ch]) * inv_alpha + ROUND_HALF) / FULL_SCALE;
         blended[ch] = (sum > FULL_SCALE) ? CHAN_MAX : CHAN_W'(sum);
      end
      return blended;
   endfunction

   function automatic pixel_type random_premul_pixel();
      pixel_type pix;
      pix[ALPHA_IDX] = CHAN_W'($urandom_range(0, FULL_SCALE));
      for (int ch = 0; ch < ALPHA_IDX; ch++)
         pix[ch] = CHAN_W'($urandom_range(0, int'(pix[ALPHA_IDX])));
      return pix;
   endfunction

   task automatic go_idle();
      if (req_valid_level) begin
         req_tvalid <= 1'b0;
         req_valid_level = 1'b0;
      end
   endtask

   // called just after a rising edge; returns after the transfer and any idle gap
   task automatic send_pixel(input pixel_type src, input pixel_type dst,
                             input logic [CHAN_W-1:0] cov);
      pixel_type scaled;
      pixel_type blended;
      int gap;
      req_tvalid <= 1'b1;
      req_valid_level = 1'b1;
      req_tdata <= {cov, dst, src};
      do @(posedge clock); while (!req_tready);
      scaled = scale_by_coverage(src, cov);
      blended = composite_over(scaled, dst);
      expected_pixels.push_back(blended);
      pixels_sent++;
      if (scaled[ALPHA_IDX] == CHAN_ZERO) alpha_zero_count++;
      else if (scaled[ALPHA_IDX] == CHAN_MAX) alpha_full_count++;
      else begin
         blended_count++;
         for (int ch = 0; ch < NUM_CHAN; ch++)
            if (int'(scaled[ch]) + int'(dst[ch]) > FULL_SCALE && blended[ch] == CHAN_MAX)
               saturated_count++;
      end
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = $urandom_range(1, 8);
         go_idle();
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      go_idle();
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic record_failure(input string what, input pixel_type want,
                                 input logic [PIXEL_W-1:0] got);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
   endtask

   task automatic test_directed_corners();
      send_pixel(32'h00000000, 32'h00000000, 8'h00);
      send_pixel(32'hffffffff, 32'hffffffff, 8'hff);
      send_pixel(32'hffffffff, 32'h12345678, 8'h00);   // zero coverage
      send_pixel(32'h00ffffff, 32'h9abcdef0, 8'hff);   // zero source alpha
      send_pixel(32'hff102030, 32'hffffffff, 8'hff);   // opaque source replaces
      send_pixel(32'h80402010, 32'hffffffff, 8'hff);   // half alpha over white
      send_pixel(32'h40ffffff, 32'hffffffff, 8'hff);   // colour above alpha, clamps
      send_pixel(32'h80ff00ff, 32'hff00ff00, 8'h80);   // colour above alpha, scaled
      send_pixel(32'hffffffff, 32'h80808080, 8'h01);
      send_pixel(32'hffffffff, 32'h80808080, 8'hfe);
      send_pixel(32'h01ffffff, 32'hcafef00d, 8'h01);   // scaled alpha rounds to zero
      send_pixel(32'h01010101, 32'hffffffff, 8'hff);
      send_pixel(32'hfe7f3f1f, 32'h00000000, 8'hff);
      send_pixel(32'haaaaaaaa, 32'h55555555, 8'haa);
      send_pixel(32'h55555555, 32'haaaaaaaa, 8'h55);
      send_pixel(32'h7f7f7f7f, 32'hffffffff, 8'h7f);
      send_pixel(32'hffffffff, 32'hffffffff, 8'h80);
      send_pixel(32'h80000000, 32'hff0000ff, 8'hc0);
   endtask

   task automatic test_random_pixels(input int count);
      pixel_type src;
      pixel_type dst;
      logic [CHAN_W-1:0] cov;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         cov = CHAN_W'($urandom);
         if (pick < 35) begin
            src = $urandom;
            dst = $urandom;
         end else if (pick < 65) begin
            src = random_premul_pixel();
            dst = random_premul_pixel();
         end else if (pick < 80) begin
            src = random_premul_pixel();
            dst = $urandom;
            case ($urandom_range(0, 4))
               0: cov = CHAN_ZERO;
               1: cov = 8'h01;
               2: cov = 8'hfe;
               3: cov = CHAN_MAX;
               default: ;
            endcase
         end else if (pick < 90) begin
            src = $urandom;
            dst = $urandom;
            case ($urandom_range(0, 2))
               0: src[ALPHA_IDX] = CHAN_ZERO;
               1: src[ALPHA_IDX] = 8'h01;
               default: src[ALPHA_IDX] = CHAN_MAX;
            endcase
         end else begin
            src = random_premul_pixel();
            src[ALPHA_IDX] = CHAN_MAX;
            dst = random_premul_pixel();
            if ($urandom_range(0, 1)) cov = CHAN_MAX;
         end
         send_pixel(src, dst, cov);
      end
   endtask

   task automatic test_drain_then_resume();
      test_random_pixels(60);
      wait_for_results();
      test_random_pixels(60);
   endtask

   // result side: rsp_tready switches among four stall modes, each picked at random
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= (stall_cycle % 7 < 4);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         pixels_checked++;
         if (expected_pixels.size() == 0)
            record_failure("result with nothing pending", '0, rsp_tdata);
         else if (rsp_tdata !== expected_pixels[0]) begin
            record_failure("out_pixel mismatch", expected_pixels[0], rsp_tdata);
            void'(expected_pixels.pop_front());
         end else
            void'(expected_pixels.pop_front());
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results pending",
                  $realtime, IDLE_LIMIT, expected_pixels.size());
         $display("premultiplied_coverage_source_over_top_tb: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_pixels(600);
      test_drain_then_resume();
      test_random_pixels(610);
      wait_for_results();
      repeat (8) @(posedge clock);
      if (expected_pixels.size() != 0) failures += expected_pixels.size();
      $display("sent %0d pixels, checked %0d results, %0d mismatches",
               pixels_sent, pixels_checked, failures);
      $display("scaled alpha zero %0d, opaque %0d, blended %0d, clamped channels %0d",
               alpha_zero_count, alpha_full_count, blended_count, saturated_count);
      if (failures == 0)
         $display("premultiplied_coverage_source_over_top_tb: PASS");
      else
         $display("premultiplied_coverage_source_over_top_tb: FAIL");
      $finish;
   end

endmodule

// ===== premultiplied_coverage_source_over_top.f =====
rtl/pcso_pkg.sv
rtl/premultiplied_coverage_source_over_top.sv
bench/premultiplied_coverage_source_over_top_tb.sv
